FILE: hw/rtl/binary_heap_priority_queue_macros.svh
// Assertion macros shared by the binary heap priority queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Checked only outside reset.
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BHPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/bhpq_pkg.sv
// Package for the binary heap priority queue: codes, state type, compare function.
// No dependencies; imported by bhpq_core, binary_heap_priority_queue and the testbench.
package bhpq_pkg;

    localparam int OCC_BITS = 6;
    localparam int CMP_BITS = 32;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic {
        ORDER_MAX_FIRST = 1'b0,
        ORDER_MIN_FIRST = 1'b1
    } order_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_START,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } res_ctrl_t;

    function automatic logic outranks(logic [CMP_BITS-1:0] a, logic [CMP_BITS-1:0] b,
                                      order_t mode);
        logic r;
        unique case (mode)
            ORDER_MIN_FIRST: r = (a < b);
            ORDER_MAX_FIRST: r = (a > b);
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/bhpq_mem.sv
// Heap entry store: one write port, two registered read ports.
// No package dependencies; instantiated by bhpq_core.
module bhpq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: hw/rtl/bhpq_core.sv
// Sift-up / sift-down sequencer around the heap store.
// Depends on bhpq_pkg, bhpq_mem and the assertion macro header.
`include "binary_heap_priority_queue_macros.svh"

module bhpq_core #(
    parameter int STORE_DEPTH  = 64,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bhpq_pkg::order_t               order,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bhpq_pkg::kind_t                in_kind,
    input  logic [KEY_BITS-1:0]            in_key,
    input  logic [PAYLOAD_BITS-1:0]        in_payload,
    output bhpq_pkg::res_ctrl_t            res,
    input  logic                           res_ready,
    output logic [KEY_BITS-1:0]            res_key,
    output logic [PAYLOAD_BITS-1:0]        res_payload,
    output logic [$clog2(STORE_DEPTH)-1:0] res_count
);
    import bhpq_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW;
    localparam int PW = AW + 1;
    localparam int EW = KEY_BITS + PAYLOAD_BITS;
    localparam logic [CW-1:0] CNT_CAP = CW'(STORE_DEPTH - 1);
    localparam logic [PW-1:0] POS_ROOT = PW'(1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [EW-1:0]       last_reg, last_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;
    logic [PAYLOAD_BITS-1:0] rpay_reg, rpay_next;
    status_t             status_reg, status_next;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;
    logic [AW-1:0] mem_rd_addr_a;
    logic [AW-1:0] mem_rd_addr_b;
    logic [EW-1:0] rd_a;
    logic [EW-1:0] rd_b;

    logic [PW-1:0] left;
    logic [PW-1:0] count_ext;
    logic [EW-1:0] item;
    logic          up_move;
    logic          pick_right;
    logic [EW-1:0] child_val;
    logic [PW-1:0] child_idx;
    logic          dn_move;
    logic          leaf;

    bhpq_mem #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // entries are {payload, key}, key in the low bits
    assign item       = {pay_reg, key_reg};
    assign left       = {pos_reg[PW-2:0], 1'b0};
    assign count_ext  = PW'(count_reg);
    assign leaf       = (left > count_ext);
    assign up_move    = outranks(CMP_BITS'(key_reg), CMP_BITS'(rd_a[KEY_BITS-1:0]), order);
    assign pick_right = (left != count_ext) &&
                        outranks(CMP_BITS'(rd_b[KEY_BITS-1:0]),
                                 CMP_BITS'(rd_a[KEY_BITS-1:0]), order);
    assign child_val  = pick_right ? rd_b : rd_a;
    assign child_idx  = pick_right ? (left + PW'(1)) : left;
    assign dn_move    = outranks(CMP_BITS'(child_val[KEY_BITS-1:0]),
                                 CMP_BITS'(last_reg[KEY_BITS-1:0]), order);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == KIND_INSERT)
                    begin
                        state_next = (count_reg == CNT_CAP) ? ST_RESULT : ST_UP_RD;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_RESULT : ST_DN_START;
                    end
                end
            end
            ST_UP_RD:    state_next = (pos_reg == POS_ROOT) ? ST_RESULT : ST_UP_CMP;
            ST_UP_CMP:   state_next = up_move ? ST_UP_RD : ST_RESULT;
            ST_DN_START: state_next = ST_DN_LOAD;
            ST_DN_LOAD:  state_next = ST_DN_RD;
            ST_DN_RD:    state_next = leaf ? ST_RESULT : ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_move ? ST_DN_RD : ST_RESULT;
            ST_RESULT:   state_next = res_ready ? ST_IDLE : ST_RESULT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb
    begin
        in_ready      = 1'b0;
        res.valid     = 1'b0;
        res.status    = status_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = AW'(pos_reg);
        mem_wr_data   = item;
        mem_rd_addr_a = AW'(pos_reg >> 1);
        mem_rd_addr_b = AW'(left + PW'(1));
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_UP_RD:
            begin
                mem_wr_en = (pos_reg == POS_ROOT);
            end
            ST_UP_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = up_move ? rd_a : item;
            end
            ST_DN_START:
            begin
                mem_rd_addr_a = AW'(POS_ROOT);
                mem_rd_addr_b = AW'(count_reg);
            end
            ST_DN_LOAD:
            begin
            end
            ST_DN_RD:
            begin
                mem_rd_addr_a = AW'(left);
                mem_wr_en     = leaf;
                mem_wr_data   = last_reg;
            end
            ST_DN_CMP:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = dn_move ? child_val : last_reg;
            end
            ST_RESULT:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        last_next   = last_reg;
        rkey_next   = rkey_reg;
        rpay_next   = rpay_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = in_key;
                    pay_next    = in_payload;
                    rkey_next   = '0;
                    rpay_next   = '0;
                    status_next = STAT_DONE;
                    pos_next    = count_ext + PW'(1);
                    if (in_kind == KIND_INSERT)
                    begin
                        if (count_reg == CNT_CAP)
                        begin
                            status_next = STAT_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == POS_ROOT)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_UP_CMP:
            begin
                if (up_move)
                begin
                    pos_next = pos_reg >> 1;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_DN_START:
            begin
            end
            ST_DN_LOAD:
            begin
                rkey_next = rd_a[KEY_BITS-1:0];
                rpay_next = rd_a[EW-1:KEY_BITS];
                last_next = rd_b;
                pos_next  = POS_ROOT;
            end
            ST_DN_RD:
            begin
                if (leaf)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_DN_CMP:
            begin
                if (dn_move)
                begin
                    pos_next = child_idx;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        pay_reg    <= pay_next;
        last_reg   <= last_next;
        rkey_reg   <= rkey_next;
        rpay_reg   <= rpay_next;
        status_reg <= status_next;
    end

    assign res_key     = rkey_reg;
    assign res_payload = rpay_reg;
    assign res_count   = count_reg;

    `BHPQ_ASSERT(a_count_cap, clk, rst_n, (count_reg <= CNT_CAP), "entry count above capacity")
    `BHPQ_ASSERT(a_idle_no_write, clk, rst_n, (state_reg == ST_IDLE) |-> !mem_wr_en, "write while idle")
    `BHPQ_ASSERT(a_count_at_result, clk, rst_n, (count_reg != $past(count_reg)) |-> (state_reg == ST_RESULT), "count moved outside result")
    `BHPQ_ASSERT(a_parent_in_heap, clk, rst_n, (state_reg == ST_DN_CMP) |-> (pos_reg <= count_ext), "sift-down parent past last entry")

endmodule

FILE: hw/rtl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: stream ports, mode register, result register.
// Depends on bhpq_pkg and bhpq_core.
//
// Each item is an insert or a remove; each produces one result. Items are handled one
// at a time: an insert reads the parent, compares and writes once for each level the
// new key climbs; a remove first reads the root and the last entry, then reads,
// compares and writes once for each level the last entry sinks. Each level is a
// read-compare-write on the single heap memory. The result sits in an output
// register, so a new item is taken while the previous result waits.
// The heap holds STORE_DEPTH-1 entries; no clearing pass runs after reset.
module binary_heap_priority_queue #(
    parameter int STORE_DEPTH  = 64,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data,                  // order_mode
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // key, payload
    input  logic s_tuser,                   // kind
    output logic m_tvalid,
    input  logic m_tready,
    output logic [((KEY_BITS + PAYLOAD_BITS + bhpq_pkg::OCC_BITS + 7) / 8) * 8 - 1:0] m_tdata,
                                            // out_key, out_payload, occupancy
    output logic [1:0] m_tuser              // status
);
    import bhpq_pkg::*;

    localparam int CW = $clog2(STORE_DEPTH);
    localparam int OUT_W = ((KEY_BITS + PAYLOAD_BITS + OCC_BITS + 7) / 8) * 8;

    order_t                  order_reg;
    res_ctrl_t               res;
    logic                    res_ready;
    logic [KEY_BITS-1:0]     res_key;
    logic [PAYLOAD_BITS-1:0] res_payload;
    logic [CW-1:0]           res_count;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [KEY_BITS-1:0]     out_key_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    logic [OCC_BITS-1:0]     out_occ_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_MAX_FIRST;
        end
        else if (cfg_valid)
        begin
            order_reg <= order_t'(cfg_data);
        end
    end

    bhpq_core #(
        .STORE_DEPTH  (STORE_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .order       (order_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (kind_t'(s_tuser)),
        .in_key      (s_tdata[KEY_BITS-1:0]),
        .in_payload  (s_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS]),
        .res         (res),
        .res_ready   (res_ready),
        .res_key     (res_key),
        .res_payload (res_payload),
        .res_count   (res_count)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_status_reg <= res.status;
            out_key_reg    <= res_key;
            out_pay_reg    <= res_payload;
            out_occ_reg    <= OCC_BITS'(res_count);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_W'({out_occ_reg, out_pay_reg, out_key_reg});

endmodule

FILE: tb/heap_checker.sv
`timescale 1ns / 100ps
// Checker for the binary heap priority queue: watches the config, input and result channels.
// Keeps its own heap image, predicts each result and compares it. Depends on bhpq_pkg.
module heap_checker #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);
    import bhpq_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [15:0] key;
        logic [15:0] payload;
        logic [5:0]  occupancy;
    } heap_outcome_t;

    logic [15:0]   key_mem [DEPTH];
    logic [15:0]   pay_mem [DEPTH];
    int            fill;
    order_t        order;
    heap_outcome_t outcome_q [$];

    function automatic bit ranks_above(logic [15:0] a, logic [15:0] b);
        if (order == ORDER_MIN_FIRST)
            return a < b;
        return a > b;
    endfunction

    function automatic heap_outcome_t heap_apply(kind_t kind, logic [15:0] key,
                                                 logic [15:0] payload);
        heap_outcome_t r;
        int            pos;
        int            child;
        bit            sinking;
        logic [15:0]   last_key;
        logic [15:0]   last_pay;
        r.status  = STAT_DONE;
        r.key     = '0;
        r.payload = '0;
        if (kind == KIND_INSERT)
        begin
            if (fill == DEPTH - 1)
                r.status = STAT_FULL;
            else
            begin
                pos = fill + 1;
                while (pos != 1 && ranks_above(key, key_mem[pos / 2]))
                begin
                    key_mem[pos] = key_mem[pos / 2];
                    pay_mem[pos] = pay_mem[pos / 2];
                    pos = pos / 2;
                end
                key_mem[pos] = key;
                pay_mem[pos] = payload;
                fill++;
            end
        end
        else if (fill == 0)
            r.status = STAT_EMPTY;
        else
        begin
            r.key     = key_mem[1];
            r.payload = pay_mem[1];
            last_key  = key_mem[fill];
            last_pay  = pay_mem[fill];
            pos       = 1;
            sinking   = 1'b1;
            while (sinking)
            begin
                child = pos * 2;
                if (child > fill)
                    sinking = 1'b0;
                else
                begin
                    // tie between children goes left
                    if (child < fill && ranks_above(key_mem[child + 1], key_mem[child]))
                        child++;
                    if (!ranks_above(key_mem[child], last_key))
                        sinking = 1'b0;
                    else
                    begin
                        key_mem[pos] = key_mem[child];
                        pay_mem[pos] = pay_mem[child];
                        pos = child;
                    end
                end
            end
            key_mem[pos] = last_key;
            pay_mem[pos] = last_pay;
            fill--;
        end
        r.occupancy = fill[5:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        heap_outcome_t want;
        if (!rst_n)
        begin
            fill   = 0;
            order  = ORDER_MAX_FIRST;
            errors = 0;
            outcome_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[31:0], 0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[15:0] !== want.key)
                        report_mismatch("out_key", m_tdata[15:0], want.key);
                    if (m_tdata[31:16] !== want.payload)
                        report_mismatch("out_payload", m_tdata[31:16], want.payload);
                    if (m_tdata[37:32] !== want.occupancy)
                        report_mismatch("occupancy", m_tdata[37:32], want.occupancy);
                end
            end
            if (cfg_valid && cfg_ready)
                order = order_t'(cfg_data);
            if (s_tvalid && s_tready)
                outcome_q.push_back(heap_apply(kind_t'(s_tuser), s_tdata[15:0],
                                               s_tdata[31:16]));
            pending = outcome_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the binary heap priority queue testbench: clock, reset, stimulus and verdict.
// Depends on bhpq_pkg, binary_heap_priority_queue and heap_checker.
module testbench;
    import bhpq_pkg::*;

    localparam int ITEMS = 1150;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // key, payload
    logic        s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_key, out_payload, occupancy
    logic [1:0]  m_tuser;   // status
    int          errors;
    int          pending;

    binary_heap_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    heap_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic issue(input kind_t kind, input logic [15:0] key,
                         input logic [15:0] payload, input bit steady);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {payload, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = steady ? 0 : idle_span();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_order(input order_t mode);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side back-pressure
    initial
    begin
        int busy;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            busy = idle_span();
            if (busy > 0)
            begin
                m_tready <= 1'b0;
                repeat (busy) @(negedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 200)) @(negedge clk);
            else
                repeat ($urandom_range(0, 29)) @(negedge clk);
        end
    end

    initial
    begin
        int          sent;
        int          span;
        int          insert_pct;
        int          key_style;
        bit          steady;
        kind_t       kind;
        logic [15:0] key;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // largest first: empty remove, extremes, equal keys
        write_order(ORDER_MAX_FIRST);
        issue(KIND_REMOVE, 16'($urandom), 16'($urandom), 1'b0);
        issue(KIND_INSERT, 16'hFFFF, 16'h0000, 1'b0);
        issue(KIND_INSERT, 16'h0000, 16'hFFFF, 1'b0);
        issue(KIND_INSERT, 16'h5555, 16'hAAAA, 1'b0);
        issue(KIND_INSERT, 16'h5555, 16'h1111, 1'b0);
        issue(KIND_INSERT, 16'h5555, 16'h2222, 1'b0);
        issue(KIND_INSERT, 16'hAAAA, 16'h5555, 1'b0);
        issue(KIND_INSERT, 16'h0001, 16'h8000, 1'b0);
        repeat (8) issue(KIND_REMOVE, 16'($urandom), 16'($urandom), 1'b0);

        // smallest first
        write_order(ORDER_MIN_FIRST);
        issue(KIND_INSERT, 16'h8000, 16'h0001, 1'b0);
        issue(KIND_INSERT, 16'h0000, 16'h0000, 1'b0);
        issue(KIND_INSERT, 16'hFFFF, 16'hFFFF, 1'b0);
        issue(KIND_INSERT, 16'h0000, 16'h1234, 1'b0);
        repeat (4) issue(KIND_REMOVE, 16'($urandom), 16'($urandom), 1'b0);

        sent = 0;
        while (sent < ITEMS)
        begin
            write_order(order_t'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: insert_pct = 85;
                4, 5, 6:    insert_pct = 20;
                default:    insert_pct = 50;
            endcase
            span      = (insert_pct == 85) ? $urandom_range(120, 200) : $urandom_range(40, 150);
            if (span > ITEMS - sent)
                span = ITEMS - sent;
            key_style = $urandom_range(0, 2);
            steady    = ($urandom_range(0, 3) == 0);
            repeat (span)
            begin
                kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
                case (key_style)
                    0: key = 16'($urandom);
                    1: key = 16'($urandom_range(0, 7));
                    default:
                        case ($urandom_range(0, 3))
                            0:       key = 16'h0000;
                            1:       key = 16'h0001;
                            2:       key = 16'hFFFE;
                            default: key = 16'hFFFF;
                        endcase
                endcase
                issue(kind, key, 16'($urandom), steady);
                sent++;
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
